### rtl/core/bmid_pkg.sv
package bmid_pkg;

    // field widths of the stream payload
    localparam int OP_W        = 2;
    localparam int ID_W        = 10;
    localparam int CNT_W       = 11;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // internal identifier arithmetic covers limit plus one word of slack
    localparam int IDX_W = 12;
    // bit position inside a word, enough for 64-bit words
    localparam int POS_W = 6;

    // largest limit the 11-bit register can express
    localparam int LIM_FIELD_MAX = (2 ** CNT_W) - 1;

    localparam int DEF_MAX_IDS   = 1024;
    localparam int DEF_WORD_BITS = 64;
    localparam logic [CNT_W-1:0] MAX_IDS_RESET = CNT_W'(1024);

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC_LO = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC_HI = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE     = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

    // outcome of examining one bitmap word
    typedef struct packed {
        logic             hit;
        logic             bit_set;
        logic [POS_W-1:0] pos;
    } scan_res_t;

endpackage

### rtl/core/bmid_ram.sv
module bmid_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/bmid_word_scan.sv
module bmid_word_scan import bmid_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic [OP_W-1:0]      op,
    input  logic [WORD_BITS-1:0] word,
    input  logic [IDX_W-1:0]     base,
    input  logic [IDX_W-1:0]     lim,
    input  logic [IDX_W-1:0]     id,
    output scan_res_t            res
);

    localparam int BI = $clog2(WORD_BITS);

    logic [IDX_W-1:0] rem;
    logic [IDX_W-1:0] off;
    logic [BI-1:0]    phys;

    // bit b of a word counts from the msb; pos reports b
    always_comb begin
        rem  = (lim > base) ? (lim - base) : '0;
        off  = id - base;
        phys = BI'(WORD_BITS - 1) - off[BI-1:0];
        res  = '0;
        case (op)
            OP_ALLOC_LO: begin
                // leading free bit, lowest identifier of the word
                for (int b = WORD_BITS - 1; b >= 0; b--) begin
                    if (word[WORD_BITS-1-b]) begin
                        res.hit = 1'b1;
                        res.pos = POS_W'(b);
                    end
                end
            end
            OP_ALLOC_HI: begin
                // last free bit below the limit, highest identifier of the word
                for (int b = 0; b < WORD_BITS; b++) begin
                    if (word[WORD_BITS-1-b] && (IDX_W'(b) < rem)) begin
                        res.hit = 1'b1;
                        res.pos = POS_W'(b);
                    end
                end
            end
            default: begin
                // free and query: does this word hold the identifier
                if (off < IDX_W'(WORD_BITS)) begin
                    res.hit     = 1'b1;
                    res.pos     = POS_W'(off[BI-1:0]);
                    res.bit_set = word[phys];
                end
            end
        endcase
    end

endmodule

### rtl/core/bitmap_id_allocator.sv
// Bitmap identifier allocator.
// Input items arrive on s_tvalid/s_tready/s_tdata: an operation (allocate
// lowest, allocate highest, free, query) and an identifier. Each item gives
// exactly one result item on m_tvalid/m_tready/m_tdata with a status, the
// identifier, the query answer and the allocated count after the operation.
// The limit register max_ids is written on cfg_valid/cfg_ready/cfg_data;
// the user must write it only while no item is in flight, which the block
// does not enforce; cfg_ready is always high. One item is worked on at a
// time and s_tready is high only when idle. The bitmap memory is scanned
// one word per cycle through a registered read port; a claim or a free
// adds a write-back step before the result. A free or query out of range
// skips the scan and goes straight to the result.
// Reset clears the count, restores max_ids to 1024 and marks every word as
// unwritten, which reads as all free; no clearing pass is needed.
// A finished result waits in the output register while m_tready is low,
// and the next item is not taken until that result has been loaded.
module bitmap_id_allocator import bmid_pkg::*; #(
    parameter int MAX_IDS   = DEF_MAX_IDS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // op [1:0], id [11:2], zero [15:12]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // status [1:0], result_id [11:2],
                                              // is_free [12], used_count [23:13]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CNT_W-1:0]       cfg_data
);

    localparam int LIM_CAP   = (MAX_IDS < LIM_FIELD_MAX) ? MAX_IDS : LIM_FIELD_MAX;
    localparam int NUM_WORDS = (LIM_CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int WI        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BI        = $clog2(WORD_BITS);
    localparam logic [WI-1:0]    LAST_WORD = WI'(NUM_WORDS - 1);
    localparam logic [IDX_W-1:0] LAST_BASE = IDX_W'((NUM_WORDS - 1) * WORD_BITS);
    localparam logic [IDX_W-1:0] WB_IDX    = IDX_W'(WORD_BITS);
    localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(LIM_CAP);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       max_ids_reg, max_ids_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [CNT_W-1:0]       lim_reg, lim_next;
    logic [WI-1:0]          addr_reg, addr_next;
    logic [IDX_W-1:0]       ibase_reg, ibase_next;
    logic                   more_reg, more_next;
    logic                   pend_reg, pend_next;
    logic [WI-1:0]          paddr_reg, paddr_next;
    logic [IDX_W-1:0]       pbase_reg, pbase_next;
    logic [NUM_WORDS-1:0]   valid_reg, valid_next;
    logic [WORD_BITS-1:0]   word_reg, word_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [IDX_W-1:0]       res_id_reg, res_id_next;
    logic                   res_free_reg, res_free_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [OP_W-1:0]      in_op;
    logic [ID_W-1:0]      in_id;
    logic [CNT_W-1:0]     lim_now;
    logic [IDX_W-1:0]     lim_idx;
    logic                 scan_up;
    logic [WI-1:0]        end_word;
    logic                 rd_en;
    logic                 ram_we;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] word_eff;
    logic [WORD_BITS-1:0] wr_data;
    logic [IDX_W-1:0]     ident;
    scan_res_t            scan;

    assign in_op     = s_tdata[1:0];
    assign in_id     = s_tdata[11:2];
    assign lim_now   = (max_ids_reg > CAP_CNT) ? CAP_CNT : max_ids_reg;
    assign lim_idx   = IDX_W'(lim_reg);
    assign scan_up   = (op_reg != OP_ALLOC_HI);
    assign end_word  = scan_up ? LAST_WORD : '0;
    assign word_eff  = valid_reg[paddr_reg] ? rd_data : '1;
    assign ident     = pbase_reg + IDX_W'(scan.pos);
    assign wr_data   = word_reg ^ ({{(WORD_BITS-1){1'b0}}, 1'b1}
                                   << (BI'(WORD_BITS - 1) - pos_reg[BI-1:0]));

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

    // bitmap words
    bmid_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (paddr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // shared word examiner
    bmid_word_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .op   (op_reg),
        .word (word_eff),
        .base (pbase_reg),
        .lim  (lim_idx),
        .id   (IDX_W'(id_reg)),
        .res  (scan)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        max_ids_next    = max_ids_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        lim_next        = lim_reg;
        addr_next       = addr_reg;
        ibase_next      = ibase_reg;
        more_next       = more_reg;
        pend_next       = pend_reg;
        paddr_next      = paddr_reg;
        pbase_next      = pbase_reg;
        valid_next      = valid_reg;
        word_next       = word_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_free_next   = res_free_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        ram_we          = 1'b0;

        // limit register write
        if (cfg_valid) begin
            max_ids_next = cfg_data;
        end

        // result taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                more_next = 1'b0;
                pend_next = 1'b0;
                if (s_tvalid) begin
                    op_next  = in_op;
                    id_next  = in_id;
                    lim_next = lim_now;
                    if (((in_op == OP_FREE) || (in_op == OP_QUERY))
                        && ({1'b0, in_id} >= lim_now)) begin
                        res_status_next = ST_RANGE;
                        res_id_next     = IDX_W'(in_id);
                        res_free_next   = 1'b0;
                        state_next      = S_DONE;
                    end else begin
                        addr_next  = (in_op == OP_ALLOC_HI) ? LAST_WORD : '0;
                        ibase_next = (in_op == OP_ALLOC_HI) ? LAST_BASE : '0;
                        more_next  = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue side: one word read per cycle
                rd_en     = more_reg;
                pend_next = more_reg;
                if (more_reg) begin
                    paddr_next = addr_reg;
                    pbase_next = ibase_reg;
                    if (addr_reg == end_word) begin
                        more_next = 1'b0;
                    end else if (scan_up) begin
                        addr_next  = addr_reg + WI'(1);
                        ibase_next = ibase_reg + WB_IDX;
                    end else begin
                        addr_next  = addr_reg - WI'(1);
                        ibase_next = ibase_reg - WB_IDX;
                    end
                end
                // evaluate side: word read in the previous cycle
                if (pend_reg) begin
                    case (op_reg)
                        OP_ALLOC_LO: begin
                            if ((pbase_reg >= lim_idx)
                                || (scan.hit && (ident >= lim_idx))
                                || (!scan.hit && (paddr_reg == LAST_WORD))) begin
                                res_status_next = ST_NONE_FREE;
                                res_id_next     = '0;
                                res_free_next   = 1'b0;
                                state_next      = S_DONE;
                            end else if (scan.hit) begin
                                word_next       = word_eff;
                                pos_next        = scan.pos;
                                res_status_next = ST_OK;
                                res_id_next     = ident;
                                res_free_next   = 1'b0;
                                state_next      = S_WRITE;
                            end
                        end
                        OP_ALLOC_HI: begin
                            if (scan.hit) begin
                                word_next       = word_eff;
                                pos_next        = scan.pos;
                                res_status_next = ST_OK;
                                res_id_next     = ident;
                                res_free_next   = 1'b0;
                                state_next      = S_WRITE;
                            end else if (paddr_reg == '0) begin
                                res_status_next = ST_NONE_FREE;
                                res_id_next     = '0;
                                res_free_next   = 1'b0;
                                state_next      = S_DONE;
                            end
                        end
                        default: begin
                            res_id_next   = IDX_W'(id_reg);
                            res_free_next = 1'b0;
                            if (scan.hit) begin
                                if (op_reg == OP_QUERY) begin
                                    res_status_next = ST_OK;
                                    res_free_next   = scan.bit_set;
                                    state_next      = S_DONE;
                                end else if (scan.bit_set) begin
                                    res_status_next = ST_ALREADY_FREE;
                                    state_next      = S_DONE;
                                end else begin
                                    word_next       = word_eff;
                                    pos_next        = scan.pos;
                                    res_status_next = ST_OK;
                                    state_next      = S_WRITE;
                                end
                            end else if (paddr_reg == LAST_WORD) begin
                                res_status_next = ST_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                    endcase
                    // scan ends: keep the address of the word just examined
                    if (state_next != S_SCAN) begin
                        more_next  = 1'b0;
                        pend_next  = 1'b0;
                        paddr_next = paddr_reg;
                        pbase_next = pbase_reg;
                    end
                end
            end
            S_WRITE: begin
                // flip the chosen bit and update the count
                ram_we                = 1'b1;
                valid_next[paddr_reg] = 1'b1;
                if (op_reg == OP_FREE) begin
                    if (count_reg != '0) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                // load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {count_reg, res_free_reg,
                                     res_id_reg[ID_W-1:0], res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            max_ids_reg  <= MAX_IDS_RESET;
            count_reg    <= '0;
            more_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            max_ids_reg  <= max_ids_next;
            count_reg    <= count_next;
            more_reg     <= more_next;
            pend_reg     <= pend_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        lim_reg        <= lim_next;
        addr_reg       <= addr_next;
        ibase_reg      <= ibase_next;
        paddr_reg      <= paddr_next;
        pbase_reg      <= pbase_next;
        word_reg       <= word_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_free_reg   <= res_free_next;
        m_data_reg     <= m_data_next;
    end

    // count never exceeds the identifiers that can be handed out
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("allocated count beyond capacity");

    // a bitmap write is always followed by the result stage
    a_write_then_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (state_reg == S_DONE))
        else $error("bitmap write not followed by result");

    // a successful allocation lies below the limit
    a_alloc_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DONE) && (res_status_reg == ST_OK)
         && ((op_reg == OP_ALLOC_LO) || (op_reg == OP_ALLOC_HI)))
        |-> (res_id_reg < lim_idx))
        else $error("allocated identifier at or beyond limit");

endmodule

### test/tb_top.sv
module tb_top;
    import bmid_pkg::*;

    localparam int WB       = DEF_WORD_BITS;
    localparam int NW       = DEF_MAX_IDS / DEF_WORD_BITS;
    localparam int SHOW_MAX = 10;

    // receiver behavior modes
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_LONG} rx_mode_e;

    // one result item as the block should return it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     rid;
        logic                is_free;
        logic [CNT_W-1:0]    used;
    } id_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;     // op [1:0], id [11:2], zero [15:12]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // status [1:0], result_id [11:2],
                                              // is_free [12], used_count [23:13]
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CNT_W-1:0]       cfg_data = '0;

    // shadow copy of the allocator state
    logic [WB-1:0]    shadow_free [NW];
    int               shadow_used;
    logic [CNT_W-1:0] shadow_max;

    id_result_t expected_results[$];

    int mismatches  = 0;
    int items_sent  = 0;
    int results_in  = 0;
    int cfg_writes  = 0;
    int burst_left  = 0;
    int status_hits [4];

    bitmap_id_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #4000000;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic int current_limit();
        return (shadow_max < DEF_MAX_IDS) ? int'(shadow_max) : DEF_MAX_IDS;
    endfunction

    // bit 0 of a word's ids is the word's msb
    function automatic bit id_is_free(int ident);
        return shadow_free[ident / WB][WB - 1 - (ident % WB)];
    endfunction

    function automatic void claim_id(int ident);
        shadow_free[ident / WB][WB - 1 - (ident % WB)] = 1'b0;
        shadow_used++;
    endfunction

    // predict the result of one accepted item and update the shadow state
    function automatic id_result_t allocator_outcome(logic [OP_W-1:0] op,
                                                      logic [ID_W-1:0] id);
        id_result_t r;
        int lim;
        int nwords;
        int w;
        int b;
        int lead;
        int ident;
        bit done;
        r = '0;
        lim = current_limit();
        done = 1'b0;
        case (op)
            OP_ALLOC_LO: begin
                r.status = ST_NONE_FREE;
                nwords = (lim + WB - 1) / WB;
                if (nwords > NW) nwords = NW;
                for (w = 0; w < nwords && !done; w++) begin
                    if (shadow_free[w] != '0) begin
                        done = 1'b1;
                        lead = WB;
                        for (b = WB - 1; b >= 0; b--) begin
                            if (shadow_free[w][WB - 1 - b]) lead = b;
                        end
                        ident = w * WB + lead;
                        // leading free bit past the limit fails the whole scan
                        if (ident < lim) begin
                            claim_id(ident);
                            r.status = ST_OK;
                            r.rid = ident[ID_W-1:0];
                        end
                    end
                end
            end
            OP_ALLOC_HI: begin
                r.status = ST_NONE_FREE;
                for (ident = lim - 1; ident >= 0 && !done; ident--) begin
                    if (id_is_free(ident)) begin
                        done = 1'b1;
                        claim_id(ident);
                        r.status = ST_OK;
                        r.rid = ident[ID_W-1:0];
                    end
                end
            end
            default: begin
                r.rid = id;
                if (int'(id) >= lim) begin
                    r.status = ST_RANGE;
                end else if (op == OP_FREE) begin
                    if (id_is_free(int'(id))) begin
                        r.status = ST_ALREADY_FREE;
                    end else begin
                        shadow_free[id / WB][WB - 1 - (id % WB)] = 1'b1;
                        if (shadow_used > 0) shadow_used--;
                    end
                end else begin
                    r.is_free = id_is_free(int'(id));
                end
            end
        endcase
        r.used = shadow_used[CNT_W-1:0];
        return r;
    endfunction

    // an allocated id within the limit, or a random one if none
    function automatic int pick_taken(int lim);
        int start;
        int j;
        int c;
        int got;
        got = $urandom_range(0, 1023);
        if (lim > 0 && shadow_used > 0) begin
            start = $urandom_range(0, lim - 1);
            for (j = lim - 1; j >= 0; j--) begin
                c = (start + j) % lim;
                if (!id_is_free(c)) got = c;
            end
        end
        return got;
    endfunction

    // send one item, entered and left at a falling edge
    task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = {4'b0000, id, op};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(allocator_outcome(op, id));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (24) @(negedge aclk);
    endtask

    // write max_ids once the block has drained
    task automatic set_limit(logic [CNT_W-1:0] value);
        s_tvalid = 1'b0;
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        shadow_max = value;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // random traffic with a given share of allocations
    task automatic run_mix(int n, int alloc_pct);
        int k;
        int r;
        int id;
        logic [OP_W-1:0] op;
        for (k = 0; k < n; k++) begin
            r  = $urandom_range(0, 99);
            id = $urandom_range(0, 1023);
            if (r < alloc_pct) begin
                op = $urandom_range(0, 1) ? OP_ALLOC_HI : OP_ALLOC_LO;
            end else if (r < alloc_pct + (100 - alloc_pct) * 3 / 4) begin
                op = OP_FREE;
                if ($urandom_range(0, 3) != 0) id = pick_taken(current_limit());
            end else begin
                op = OP_QUERY;
                if ($urandom_range(0, 1) != 0) id = pick_taken(current_limit());
            end
            send_item(op, id[ID_W-1:0]);
        end
    endtask

    // allocation order at the reset limit
    task automatic test_alloc_order();
        send_item(OP_QUERY, 10'd0);
        send_item(OP_ALLOC_LO, 10'd0);
        send_item(OP_ALLOC_HI, 10'h3FF);
        send_item(OP_QUERY, 10'd0);
        send_item(OP_QUERY, 10'h3FF);
        send_item(OP_ALLOC_LO, 10'h155);
    endtask

    // frees, a double free and a query after them
    task automatic test_free_errors();
        send_item(OP_FREE, 10'd0);
        send_item(OP_FREE, 10'd0);
        send_item(OP_FREE, 10'h3FF);
        send_item(OP_FREE, 10'd1);
        send_item(OP_QUERY, 10'h3FF);
    endtask

    // zero limit, one-id limit, saturated limit and a lowered limit
    task automatic test_limit_edges();
        set_limit(11'd0);
        send_item(OP_ALLOC_LO, 10'd0);
        send_item(OP_ALLOC_HI, 10'd0);
        send_item(OP_FREE, 10'd5);
        send_item(OP_QUERY, 10'd0);
        set_limit(11'd1);
        send_item(OP_ALLOC_LO, 10'd0);
        // word 0 still has free bits, all past the limit
        send_item(OP_ALLOC_LO, 10'd0);
        send_item(OP_ALLOC_HI, 10'd0);
        send_item(OP_FREE, 10'd1);
        set_limit(11'h7FF);
        send_item(OP_ALLOC_HI, 10'd0);
        // id above a lowered limit can no longer be freed
        set_limit(11'd512);
        send_item(OP_FREE, 10'h3FF);
        send_item(OP_QUERY, 10'h3FF);
        send_item(OP_FREE, 10'd0);
        set_limit(11'd1024);
        send_item(OP_FREE, 10'h3FF);
    endtask

    task automatic test_random_traffic();
        set_limit(11'd64);
        run_mix(60, 70);
        set_limit(11'd1024);
        run_mix(70, 50);
        set_limit(11'h7FF);
        run_mix(40, 50);
        set_limit(11'd1);
        run_mix(20, 50);
        set_limit(11'd0);
        run_mix(15, 40);
        set_limit(11'd65);
        run_mix(50, 60);
        set_limit(11'($urandom_range(2, 1023)));
        run_mix(60, 50);
        set_limit(11'd130);
        run_mix(60, 40);
        set_limit(11'd1024);
        run_mix(30, 50);
    endtask

    // receiver ready pattern, switching modes every so often
    rx_mode_e rx_mode = RX_OPEN;
    int       rx_phase_left = 0;
    int       rx_run_left = 0;
    bit       rx_hold = 1'b0;

    always @(negedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 2));
            rx_phase_left = $urandom_range(20, 120);
        end
        rx_phase_left--;
        case (rx_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_COIN: m_tready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_run_left == 0) begin
                    rx_hold = ~rx_hold;
                    rx_run_left = rx_hold ? $urandom_range(1, 20) : $urandom_range(1, 6);
                end
                rx_run_left--;
                m_tready <= ~rx_hold;
            end
        endcase
    end

    // compare each result item against the oldest prediction
    always @(posedge aclk) begin
        id_result_t want;
        id_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status  = m_tdata[1:0];
            got.rid     = m_tdata[11:2];
            got.is_free = m_tdata[12];
            got.used    = m_tdata[23:13];
            results_in++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result: status %0d id %0d free %0d used %0d",
                             got.status, got.rid, got.is_free, got.used);
            end else begin
                want = expected_results.pop_front();
                status_hits[want.status]++;
                if (got.status !== want.status || got.rid !== want.rid ||
                    got.is_free !== want.is_free || got.used !== want.used) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("mismatch: exp st %0d id %0d free %0d used %0d, %s %0d %0d %0d %0d",
                                 want.status, want.rid, want.is_free, want.used,
                                 "got st/id/free/used", got.status, got.rid,
                                 got.is_free, got.used);
                end
            end
        end
    end

    // reset, tests, verdict
    initial begin
        int w;
        for (w = 0; w < NW; w++) shadow_free[w] = '1;
        for (w = 0; w < 4; w++) status_hits[w] = 0;
        shadow_used = 0;
        shadow_max  = MAX_IDS_RESET;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_alloc_order();
        test_free_errors();
        test_limit_edges();
        test_random_traffic();

        s_tvalid = 1'b0;
        wait_idle();
        if (expected_results.size() != 0) mismatches++;

        $display("sent %0d items, checked %0d results, %0d limit writes",
                 items_sent, results_in, cfg_writes);
        $display("outcomes: ok %0d, none free %0d, out of range %0d, already free %0d",
                 status_hits[ST_OK], status_hits[ST_NONE_FREE],
                 status_hits[ST_RANGE], status_hits[ST_ALREADY_FREE]);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
